// ===== hw/rtl/vmfd_pkg.sv =====
// shared item types and constants for the view matrix builder
package vmfd_pkg;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [31:0] fwd_x;
    logic signed [31:0] fwd_y;
    logic signed [31:0] fwd_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col_one;
    logic signed [31:0] col_two;
    logic signed [31:0] col_three;
    logic               degenerate;
    logic               last_row;
  } out_item_t;

  localparam logic [1:0] LAST_ROW = 2'd3;

endpackage

// ===== hw/rtl/view_matrix_from_direction.sv =====
// view matrix builder: pipelined axis derivation and row serializer
//
// Usage: each transfer on the input channel carries a camera position, a forward
// direction and an up hint in signed fixed point with FRAC_BITS fraction bits.
// The block answers with four rows on the output channel, rows 0 to 2 holding
// the right, up and forward axis components, row 3 the negated, saturated dot
// products of those axes with the position. degenerate is set on all four rows
// when forward or up x forward had zero length.
// The config channel writes right_handed (always ready); write it only while
// no item is in flight.
// The first row is valid once the item has passed the whole pipeline, and the
// rest follow one per cycle while out_stall_i is low. The four-row output
// serializer takes an item only after the last row of the previous one is taken;
// the arithmetic pipeline itself (two normalizers with a 32-step square root
// and a FRAC_BITS+1-step divider each) takes a new item every cycle unless held.
// Reset clears all valid bits and right_handed. The whole pipeline holds, and
// in_stall_o rises, while its last stage is occupied and the serializer is busy.
module view_matrix_from_direction import vmfd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int FB = FRAC_BITS;
  localparam int XW = FB + 34;
  localparam int MW = FB + 33;
  localparam int AW = FB + 2;
  localparam int YW = FB + 3;
  localparam int PW = FB + 35;
  localparam int SW = PW + 2;
  localparam int QW = FB + 1;
  localparam int NL = FB + 41;
  localparam int K_NA = 1;
  localparam int K_BMUL = K_NA + NL;
  localparam int K_BSUB = K_BMUL + 1;
  localparam int K_BLOAD = K_BMUL + 2;
  localparam int K_NB = K_BMUL + 3;
  localparam int K_CMUL = K_NB + NL;
  localparam int K_CSUB = K_CMUL + 1;
  localparam int K_DMUL = K_CMUL + 2;
  localparam int K_DSUM = K_CMUL + 3;
  localparam int K_DFIN = K_CMUL + 4;
  localparam int NSTG = K_DFIN + 1;

  typedef struct packed {
    logic [2:0][31:0]    cam;
    logic [2:0][31:0]    up;
    logic [2:0]          vneg;
    logic [2:0][MW-1:0]  m;
    logic [2:0][61:0]    sq;
    logic [63:0]         n;
    logic [63:0]         res;
    logic [31:0]         len;
    logic [2:0][32:0]    rem;
    logic [2:0][QW-1:0]  q;
    logic                nz;
    logic                deg;
    logic [2:0][AW-1:0]  az;
    logic [2:0][AW-1:0]  ax;
    logic [2:0][YW-1:0]  ay;
    logic [8:0][PW-1:0]  pr;
    logic [2:0][XW-1:0]  cr;
    logic [2:0][SW-1:0]  ds;
    logic [2:0][31:0]    tr;
  } pipe_t;

  function automatic logic signed [PW-1:0] smul(logic signed [PW-1:0] a,
                                                logic signed [PW-1:0] b);
    return a * b;
  endfunction

  // sign and magnitude of the vector held in cr
  function automatic pipe_t load_vec(pipe_t s, logic neg);
    pipe_t o;
    logic signed [XW-1:0] v;
    logic signed [XW-1:0] av;
    o = s;
    for (int i = 0; i < 3; i++) begin
      v = neg ? -$signed(s.cr[i]) : $signed(s.cr[i]);
      av = v[XW-1] ? -v : v;
      o.vneg[i] = v[XW-1];
      o.m[i] = av[MW-1:0];
    end
    return o;
  endfunction

  // one step of the normalizer used for both axes: range shift, squares, sum, sqrt, divide
  function automatic pipe_t norm_step(int j, pipe_t s);
    pipe_t o;
    logic [MW-1:0] orm;
    logic [63:0] bit_v;
    logic [63:0] tst;
    logic [32:0] r;
    logic [31:0] d;
    logic qb;
    int a;
    o = s;
    if (j < 5) begin
      a = 16 >> j;
      orm = s.m[0] | s.m[1] | s.m[2];
      if ((orm >> (30 + a)) != '0) begin
        for (int i = 0; i < 3; i++) o.m[i] = s.m[i] >> a;
      end
    end else if (j == 5) begin
      for (int i = 0; i < 3; i++) o.sq[i] = 62'(s.m[i][30:0]) * 62'(s.m[i][30:0]);
    end else if (j == 6) begin
      o.n = 64'(s.sq[0]) + 64'(s.sq[1]) + 64'(s.sq[2]);
      o.res = '0;
      o.nz = (o.n == '0);
    end else if (j < 39) begin
      bit_v = 64'd1 << (62 - 2 * (j - 7));
      tst = s.res + bit_v;
      if (s.n >= tst) begin
        o.n = s.n - tst;
        o.res = (s.res >> 1) + bit_v;
      end else begin
        o.res = s.res >> 1;
      end
    end else begin
      d = (j == 39) ? s.res[31:0] : s.len;
      o.len = d;
      for (int i = 0; i < 3; i++) begin
        r = (j == 39) ? {2'b00, s.m[i][30:0]} : {s.rem[i][31:0], 1'b0};
        qb = (r >= {1'b0, d});
        o.rem[i] = qb ? (r - {1'b0, d}) : r;
        o.q[i] = {s.q[i][QW-2:0], qb};
      end
    end
    return o;
  endfunction

  function automatic logic [2:0][AW-1:0] norm_out(pipe_t s);
    logic [2:0][AW-1:0] o;
    logic [AW-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag = {1'b0, s.q[i]};
      o[i] = s.nz ? '0 : (s.vneg[i] ? -mag : mag);
    end
    return o;
  endfunction

  function automatic pipe_t step(int k, pipe_t s, logic rh);
    pipe_t o;
    logic signed [PW-1:0] df;
    logic signed [SW-1:0] sh;
    logic signed [SW-1:0] ng;
    o = s;
    if (k == 0) begin
      o = load_vec(s, rh);
      o.deg = 1'b0;
    end else if (k >= K_NA && k < K_BMUL) begin
      if (k - K_NA == NL - 1) begin
        o.az = norm_out(s);
        o.deg = s.nz;
      end else begin
        o = norm_step(k - K_NA, s);
      end
    end else if (k == K_BMUL) begin
      o.pr[0] = smul($signed(s.up[1]), $signed(s.az[2]));
      o.pr[1] = smul($signed(s.up[2]), $signed(s.az[1]));
      o.pr[2] = smul($signed(s.up[2]), $signed(s.az[0]));
      o.pr[3] = smul($signed(s.up[0]), $signed(s.az[2]));
      o.pr[4] = smul($signed(s.up[0]), $signed(s.az[1]));
      o.pr[5] = smul($signed(s.up[1]), $signed(s.az[0]));
    end else if (k == K_BSUB) begin
      for (int i = 0; i < 3; i++) begin
        df = $signed(s.pr[2*i]) - $signed(s.pr[2*i+1]);
        o.cr[i] = df[XW-1:0];
      end
    end else if (k == K_BLOAD) begin
      o = load_vec(s, 1'b0);
    end else if (k >= K_NB && k < K_CMUL) begin
      if (k - K_NB == NL - 1) begin
        o.ax = norm_out(s);
        o.deg = s.deg | s.nz;
      end else begin
        o = norm_step(k - K_NB, s);
      end
    end else if (k == K_CMUL) begin
      o.pr[0] = smul($signed(s.az[1]), $signed(s.ax[2]));
      o.pr[1] = smul($signed(s.az[2]), $signed(s.ax[1]));
      o.pr[2] = smul($signed(s.az[2]), $signed(s.ax[0]));
      o.pr[3] = smul($signed(s.az[0]), $signed(s.ax[2]));
      o.pr[4] = smul($signed(s.az[0]), $signed(s.ax[1]));
      o.pr[5] = smul($signed(s.az[1]), $signed(s.ax[0]));
    end else if (k == K_CSUB) begin
      for (int i = 0; i < 3; i++) begin
        df = ($signed(s.pr[2*i]) - $signed(s.pr[2*i+1])) >>> FB;
        o.ay[i] = df[YW-1:0];
      end
    end else if (k == K_DMUL) begin
      for (int i = 0; i < 3; i++) begin
        o.pr[i]   = smul($signed(s.ax[i]), $signed(s.cam[i]));
        o.pr[3+i] = smul($signed(s.ay[i]), $signed(s.cam[i]));
        o.pr[6+i] = smul($signed(s.az[i]), $signed(s.cam[i]));
      end
    end else if (k == K_DSUM) begin
      for (int a = 0; a < 3; a++) begin
        o.ds[a] = SW'($signed(s.pr[3*a])) + SW'($signed(s.pr[3*a+1]))
                + SW'($signed(s.pr[3*a+2]));
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        sh = $signed(s.ds[a]) >>> FB;
        ng = -sh;
        if (ng[SW-1:31] == '0 || ng[SW-1:31] == '1) begin
          o.tr[a] = ng[31:0];
        end else begin
          o.tr[a] = ng[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
      end
    end
    return o;
  endfunction

  logic              rh_q;
  pipe_t             st_q [NSTG+1];
  pipe_t             in_load;
  logic [NSTG:0]     vld_q;
  logic              en;
  logic              ser_vld_q;
  logic [1:0]        row_q;
  logic [2:0][AW-1:0] ax_q;
  logic [2:0][AW-1:0] az_q;
  logic [2:0][YW-1:0] ay_q;
  logic [2:0][31:0]   tr_q;
  logic              deg_q;
  logic              ser_take;
  logic              ser_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rh_q <= 1'b0;
    end else if (cfg_valid_i) begin
      rh_q <= cfg_data_i;
    end
  end

  // forward is parked in the cross product field until the first load step
  always_comb begin
    in_load = '0;
    in_load.cam[0] = in_data_i.cam_x;
    in_load.cam[1] = in_data_i.cam_y;
    in_load.cam[2] = in_data_i.cam_z;
    in_load.up[0] = in_data_i.up_x;
    in_load.up[1] = in_data_i.up_y;
    in_load.up[2] = in_data_i.up_z;
    in_load.cr[0] = XW'(in_data_i.fwd_x);
    in_load.cr[1] = XW'(in_data_i.fwd_y);
    in_load.cr[2] = XW'(in_data_i.fwd_z);
  end

  assign ser_take = ser_vld_q && !out_stall_i;
  assign ser_free = !ser_vld_q || (ser_take && row_q == LAST_ROW);
  assign en = !vld_q[NSTG] || ser_free;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= in_load;
    end
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[g+1] <= step(g, st_q[g], rh_q);
      end
    end
  end

  // four-row serializer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      row_q <= '0;
    end else if (en && vld_q[NSTG]) begin
      ser_vld_q <= 1'b1;
      row_q <= '0;
    end else if (ser_take) begin
      if (row_q == LAST_ROW) begin
        ser_vld_q <= 1'b0;
      end else begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NSTG]) begin
      ax_q <= st_q[NSTG].ax;
      ay_q <= st_q[NSTG].ay;
      az_q <= st_q[NSTG].az;
      tr_q <= st_q[NSTG].tr;
      deg_q <= st_q[NSTG].deg;
    end
  end

  assign out_valid_o = ser_vld_q;

  always_comb begin
    out_data_o.row_index = row_q;
    out_data_o.degenerate = deg_q;
    out_data_o.last_row = (row_q == LAST_ROW);
    case (row_q)
      LAST_ROW: begin
        out_data_o.col_one = tr_q[0];
        out_data_o.col_two = tr_q[1];
        out_data_o.col_three = tr_q[2];
      end
      default: begin
        out_data_o.col_one = 32'($signed(ax_q[row_q]));
        out_data_o.col_two = 32'($signed(ay_q[row_q]));
        out_data_o.col_three = 32'($signed(az_q[row_q]));
      end
    endcase
  end

endmodule

// ===== hw/rtl/vmfd_checker.sv =====
// port-level checks on the row sequence of the view matrix builder
module vmfd_checker import vmfd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // rows of one item follow back to back in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_row) |=>
      (out_valid_o && out_data_o.row_index == $past(out_data_o.row_index) + 2'd1))
    else $error("row sequence broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_row == (out_data_o.row_index == LAST_ROW)))
    else $error("last_row does not match row_index");

  // the flag is per item, so it holds across its rows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_row) |=>
      (out_data_o.degenerate == $past(out_data_o.degenerate)))
    else $error("degenerate changed within an item");

endmodule

bind view_matrix_from_direction vmfd_checker u_vmfd_checker (.*);
